[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helper macros used by entity_slot_mask_table
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");
// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  `ASSERT_PROP(lbl, clk, rst, !(expr))
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

[sv/esmt_pkg.sv]
// ----------------------------------------------------------------------------
// esmt_pkg
// shared types and constants of the entity slot mask table
// ----------------------------------------------------------------------------
package esmt_pkg;

  // default sizes
  localparam int MAX_SLOTS_DEF = 64;
  localparam int MASK_BITS_DEF = 16;

  // fixed field widths
  localparam int FUNC_W   = 2;
  localparam int INDEX_W  = 6;
  localparam int REQ_W    = 16;
  localparam int STATUS_W = 2;

  // capacity register
  localparam int CAP_W     = 7;
  localparam int CAP_LIMIT = 1 << CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // compare width for slot positions against the capacity
  localparam int CMP_W = CAP_W + 1;

  // free slot search: slots looked at per cycle
  localparam int SCAN_W  = 8;
  localparam int SCAN_IW = 3;

  // apb port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_SLOTS_IN_USE = 1'b0;

  // operations
  localparam logic [FUNC_W-1:0] FUNC_CREATE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DESTROY = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] entity_index;
    logic [REQ_W-1:0]   component_mask;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  slot_index;
    logic [STATUS_W-1:0] status;
    logic                has_all;
    logic                is_alive;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_RESP
  } state_t;

endpackage

[sv/esmt_ram.sv]
// ----------------------------------------------------------------------------
// esmt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module esmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/entity_slot_mask_table.sv]
// ----------------------------------------------------------------------------
// entity_slot_mask_table
// table of entity slots with alive bits and component masks
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_ready/in_data carries one operation per transfer (create,
//   destroy, add components, query components). out_valid/out_ready/out_data
//   returns exactly one result per operation, in order. slots_in_use must be
//   written over the apb port only while the block is idle; it is not enforced.
// operation flow:
//   create searches the alive bits eight slots a cycle with one shared
//   priority search, one eight-slot group after another, until a free slot
//   is found or the capacity is reached. destroy, add and query on a live
//   slot read the mask ram as the operation is taken, then update or compare
//   the mask in S_EXEC and pass the result on in S_RESP. an operation on a
//   dead or out-of-range slot goes straight from S_IDLE to S_RESP.
//   one operation is in flight at a time; in_ready is low while it works.
// reset:
//   all alive bits clear at once, slots_in_use returns to 64; the mask ram
//   is not cleared since create clears a mask before any read of it.
// stall:
//   a finished result sits in the output register; the next operation is
//   taken meanwhile, and its result waits until the register frees up.
module entity_slot_mask_table #(
  parameter int MAX_SLOTS = esmt_pkg::MAX_SLOTS_DEF,
  parameter int MASK_BITS = esmt_pkg::MASK_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // operation channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  esmt_pkg::in_item_t                  in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output esmt_pkg::out_item_t                 out_data,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [esmt_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [esmt_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [esmt_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // only slots below the largest capacity value are ever reachable
  localparam int DEPTH  = (MAX_SLOTS < esmt_pkg::CAP_LIMIT) ? MAX_SLOTS
                                                            : esmt_pkg::CAP_LIMIT;
  localparam int AW     = $clog2(DEPTH);
  localparam int NCHUNK = (DEPTH + esmt_pkg::SCAN_W - 1) / esmt_pkg::SCAN_W;
  localparam int PAD    = NCHUNK * esmt_pkg::SCAN_W;
  localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PW     = CHW + esmt_pkg::SCAN_IW;

  localparam int CMP_W = esmt_pkg::CMP_W;

  esmt_pkg::state_t    state, state_next;
  logic [CHW-1:0]      chunk, chunk_next;
  esmt_pkg::out_item_t res, res_next;

  logic [esmt_pkg::FUNC_W-1:0]  op;
  logic [esmt_pkg::INDEX_W-1:0] idx;
  logic [MASK_BITS-1:0]         req;

  logic [esmt_pkg::CAP_W-1:0]   slots_in_use;
  logic [CMP_W-1:0]             cap_eff;

  logic [DEPTH-1:0]             alive;
  logic [PAD-1:0]               alive_pad;
  logic                         alive_set;
  logic                         alive_clr;
  logic [AW-1:0]                alive_addr;

  logic                         in_xfer;
  logic                         in_slot_ok;
  logic                         out_load;

  logic [esmt_pkg::SCAN_W-1:0]  chunk_bits;
  logic [esmt_pkg::SCAN_W-1:0]  chunk_free;
  logic [esmt_pkg::SCAN_IW-1:0] hit_j;
  logic                         scan_hit;
  logic                         scan_last;
  logic [PW-1:0]                scan_pos;
  logic [AW-1:0]                scan_slot;
  logic [AW-1:0]                idx_a;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [MASK_BITS-1:0]         ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [MASK_BITS-1:0]         ram_rdata;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= esmt_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[esmt_pkg::APB_ADDR_W-1] == esmt_pkg::REG_SLOTS_IN_USE) begin
      slots_in_use <= pwdata[esmt_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[esmt_pkg::APB_ADDR_W-1] == esmt_pkg::REG_SLOTS_IN_USE) begin
      prdata = esmt_pkg::APB_DATA_W'(slots_in_use);
    end
  end

  // capacity saturates at the table depth
  assign cap_eff = (CMP_W'(slots_in_use) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                          : CMP_W'(slots_in_use);

  // slot check on the incoming transfer
  assign in_xfer    = in_valid && in_ready;
  assign in_slot_ok = (CMP_W'(in_data.entity_index) < cap_eff) &&
                      alive[AW'(in_data.entity_index)];

  // operation registers, loaded on each transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op  <= in_data.func;
      idx <= in_data.entity_index;
      req <= MASK_BITS'(in_data.component_mask);
    end
  end

  assign idx_a = AW'(idx);

  // free slot search over one group of eight alive bits
  assign alive_pad  = PAD'(alive);
  assign chunk_bits = alive_pad[chunk * esmt_pkg::SCAN_W +: esmt_pkg::SCAN_W];

  always_comb begin
    for (int j = 0; j < esmt_pkg::SCAN_W; j++) begin
      chunk_free[j] = !chunk_bits[j] &&
                      (CMP_W'({chunk, esmt_pkg::SCAN_IW'(j)}) < cap_eff);
    end
  end

  always_comb begin
    hit_j = '0;
    for (int j = esmt_pkg::SCAN_W - 1; j >= 0; j--) begin
      if (chunk_free[j]) begin
        hit_j = esmt_pkg::SCAN_IW'(j);
      end
    end
  end

  assign scan_hit  = |chunk_free;
  assign scan_pos  = {chunk, hit_j};
  assign scan_slot = AW'(scan_pos);
  assign scan_last = (CMP_W'({chunk, esmt_pkg::SCAN_IW'(0)}) +
                      CMP_W'(esmt_pkg::SCAN_W)) >= cap_eff;

  // mask storage
  assign ram_raddr = AW'(in_data.entity_index);
  assign ram_waddr = (state == esmt_pkg::S_SCAN) ? scan_slot : idx_a;

  esmt_ram #(
    .WIDTH (MASK_BITS),
    .DEPTH (DEPTH)
  ) u_mask_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esmt_pkg::S_IDLE;
      chunk <= '0;
    end else begin
      state <= state_next;
      chunk <= chunk_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // sequencer next state and datapath control
  always_comb begin
    state_next = state;
    chunk_next = chunk;
    res_next   = res;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = '0;
    alive_set  = 1'b0;
    alive_clr  = 1'b0;
    alive_addr = idx_a;
    out_load   = 1'b0;
    unique case (state)
      esmt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.func == esmt_pkg::FUNC_CREATE) begin
            chunk_next = '0;
            state_next = esmt_pkg::S_SCAN;
          end else if (!in_slot_ok) begin
            res_next.slot_index = in_data.entity_index;
            res_next.status     = esmt_pkg::STATUS_INVALID;
            res_next.has_all    = 1'b0;
            res_next.is_alive   = 1'b0;
            state_next          = esmt_pkg::S_RESP;
          end else begin
            state_next = esmt_pkg::S_EXEC;
          end
        end
      end
      esmt_pkg::S_SCAN: begin
        alive_addr = scan_slot;
        if (scan_hit) begin
          alive_set           = 1'b1;
          ram_we              = 1'b1;
          res_next.slot_index = esmt_pkg::INDEX_W'(scan_pos);
          res_next.status     = esmt_pkg::STATUS_OK;
          res_next.has_all    = 1'b0;
          res_next.is_alive   = 1'b1;
          state_next          = esmt_pkg::S_RESP;
        end else if (scan_last) begin
          res_next.slot_index = '0;
          res_next.status     = esmt_pkg::STATUS_FULL;
          res_next.has_all    = 1'b0;
          res_next.is_alive   = 1'b0;
          state_next          = esmt_pkg::S_RESP;
        end else begin
          chunk_next = chunk + 1'b1;
        end
      end
      esmt_pkg::S_EXEC: begin
        res_next.slot_index = idx;
        res_next.status     = esmt_pkg::STATUS_OK;
        res_next.has_all    = 1'b0;
        res_next.is_alive   = 1'b1;
        unique case (op)
          esmt_pkg::FUNC_DESTROY: begin
            alive_clr         = 1'b1;
            ram_we            = 1'b1;
            res_next.is_alive = 1'b0;
          end
          esmt_pkg::FUNC_ADD: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | req;
          end
          default: begin
            // query compares the stored mask with the request
            res_next.has_all = ((ram_rdata & req) == req);
          end
        endcase
        state_next = esmt_pkg::S_RESP;
      end
      esmt_pkg::S_RESP: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = esmt_pkg::S_IDLE;
        end
      end
    endcase
  end

  // alive bits
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= '0;
    end else if (alive_set) begin
      alive[alive_addr] <= 1'b1;
    end else if (alive_clr) begin
      alive[alive_addr] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  // checks
  `include "assert_macros.svh"

  `ASSERT_PROP(a_busy_after_xfer, clk, rst, in_valid && in_ready |=> !in_ready)
  `ASSERT_NEVER(a_ram_write_state, clk, rst, ram_we && state != esmt_pkg::S_SCAN && state != esmt_pkg::S_EXEC)
  `ASSERT_PROP(a_full_only_create, clk, rst, out_load && res.status == esmt_pkg::STATUS_FULL |-> op == esmt_pkg::FUNC_CREATE && res.slot_index == '0)
  `ASSERT_PROP(a_create_one_slot, clk, rst, state == esmt_pkg::S_SCAN && scan_hit |=> $countones(alive) == $past($countones(alive)) + 1)

endmodule
